/* src/at_event_hex_payload_extractor_core_macros.svh */
// Assertion helpers shared by the RTL modules.
// Both expect signals named clk and arst_n in the enclosing module.
`ifndef AT_EVENT_HEX_PAYLOAD_EXTRACTOR_CORE_MACROS_SVH
`define AT_EVENT_HEX_PAYLOAD_EXTRACTOR_CORE_MACROS_SVH

// Property checked at every clock edge outside reset
`define AHPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent this cycle implies consequent next cycle
`define AHPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ahpe_pkg.sv */
package ahpe_pkg;

	// Characters with a special meaning on the modem link
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	// Receive-event tag "+EVT:RXP2P"
	localparam int TAG_LEN = 10;
	localparam int TAG_PW  = 4;
	typedef logic [TAG_PW-1:0] tag_prog_t;

	typedef enum logic [1:0] {
		ST_IDLE,   // taking characters
		ST_HELD,   // storing the character that followed a held CR
		ST_RD,     // reading one nibble pair from the line store
		ST_LD      // moving the pair into the output register
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic take_char;   // accepted non-newline character
		logic store_held;  // second store of a two-store character
		logic end_line;    // accepted newline
		logic rd_en;       // read the next nibble pair
		logic ld_out;      // load output register
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic enabled;
		logic is_nl;
		logic need_held;
		logic emit_go;
		logic rd_last;
		logic out_free;
	} dp_sts_t;

	function automatic logic [7:0] tag_char(input tag_prog_t idx);
		logic [7:0] ch;
		unique case (idx)
			4'd0:    ch = 8'h2B;  // +
			4'd1:    ch = 8'h45;  // E
			4'd2:    ch = 8'h56;  // V
			4'd3:    ch = 8'h54;  // T
			4'd4:    ch = 8'h3A;  // :
			4'd5:    ch = 8'h52;  // R
			4'd6:    ch = 8'h58;  // X
			4'd7:    ch = 8'h50;  // P
			4'd8:    ch = 8'h32;  // 2
			4'd9:    ch = 8'h50;  // P
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Hex digit value, anything else reads as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

/* src/ahpe_ctrl.sv */
module ahpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ahpe_pkg::dp_sts_t sts,
	output ahpe_pkg::dp_cmd_t cmd
);

`include "at_event_hex_payload_extractor_core_macros.svh"

	ahpe_pkg::state_t state_q;
	ahpe_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ahpe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ahpe_pkg::ST_IDLE: begin
				if (in_valid && sts.enabled) begin
					if (sts.is_nl) begin
						if (sts.emit_go) state_d = ahpe_pkg::ST_RD;
					end else if (sts.need_held) begin
						state_d = ahpe_pkg::ST_HELD;
					end
				end
			end
			ahpe_pkg::ST_HELD: state_d = ahpe_pkg::ST_IDLE;
			ahpe_pkg::ST_RD:   state_d = ahpe_pkg::ST_LD;
			ahpe_pkg::ST_LD: begin
				if (sts.out_free) begin
					state_d = sts.rd_last ? ahpe_pkg::ST_IDLE : ahpe_pkg::ST_RD;
				end
			end
			default: state_d = ahpe_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ahpe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && sts.enabled) begin
					if (sts.is_nl) cmd.end_line = 1'b1;
					else           cmd.take_char = 1'b1;
				end
			end
			ahpe_pkg::ST_HELD: cmd.store_held = 1'b1;
			ahpe_pkg::ST_RD:   cmd.rd_en = 1'b1;
			ahpe_pkg::ST_LD:   cmd.ld_out = sts.out_free;
			default: ;
		endcase
	end

	`AHPE_ASSERT(a_load_needs_room, cmd.ld_out |-> sts.out_free, "output overwritten")
	`AHPE_ASSERT_NEXT(a_held_one_cycle, state_q == ahpe_pkg::ST_HELD, in_ready, "held store stuck")

endmodule

/* src/ahpe_dp.sv */
module ahpe_dp #(
	parameter int LINE_MAX = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic [7:0]        rx_byte,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [7:0]        payload_byte,
	output logic              last_in_frame,
	output logic              inline_format,
	input  ahpe_pkg::dp_cmd_t cmd,
	output ahpe_pkg::dp_sts_t sts
);

`include "at_event_hex_payload_extractor_core_macros.svh"

	localparam int AW = $clog2(LINE_MAX);
	localparam int LW = $clog2(LINE_MAX + 1);

	logic [3:0] nib_mem [LINE_MAX];

	logic                en_q;
	logic [LW-1:0]       len_q;
	logic [AW-1:0]       colon_q;
	logic                colon_seen_q;
	ahpe_pkg::tag_prog_t prog_q;
	logic                tag_found_q;
	logic                expect_q;
	logic                cr_q;
	logic                ovf_q;
	logic [7:0]          held_q;
	logic [LW-1:0]       ptr_q;
	logic [LW-1:0]       end_q;
	logic                inl_q;
	logic                rd_last_q;
	logic [3:0]          hi_q;
	logic [3:0]          lo_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;
	logic                out_inl_q;

	// Store path: one write to the line store per cycle
	logic          st_en;
	logic [7:0]    st_char;
	logic          st_full;
	logic [LW-1:0] len_inc;

	assign st_en   = (cmd.take_char && (cr_q || rx_byte != ahpe_pkg::CHAR_CR)) || cmd.store_held;
	assign st_char = cmd.store_held ? held_q : (cr_q ? ahpe_pkg::CHAR_CR : rx_byte);
	assign st_full = len_q >= LW'(LINE_MAX);
	assign len_inc = len_q + LW'(1);

	// Tag search
	ahpe_pkg::tag_prog_t prog_inc;
	logic                tag_hit;

	always_comb begin
		if (prog_q < ahpe_pkg::TAG_PW'(ahpe_pkg::TAG_LEN) &&
				rx_byte == ahpe_pkg::tag_char(prog_q)) begin
			prog_inc = prog_q + ahpe_pkg::TAG_PW'(1);
		end else if (rx_byte == ahpe_pkg::tag_char('0)) begin
			prog_inc = ahpe_pkg::TAG_PW'(1);
		end else begin
			prog_inc = '0;
		end
	end
	assign tag_hit = prog_inc >= ahpe_pkg::TAG_PW'(ahpe_pkg::TAG_LEN);

	// End-of-line decision
	logic [LW-1:0] cp1;
	logic [LW-1:0] inl_len;
	logic          inline_ok;
	logic          expect_nx;
	logic          emit_go;
	logic [LW-1:0] first;
	logic          inl_nx;

	assign cp1       = LW'(colon_q) + LW'(1);
	assign inline_ok = colon_seen_q && (cp1 < len_q);
	assign inl_len   = len_q - cp1;

	always_comb begin
		expect_nx = expect_q;
		emit_go   = 1'b0;
		first     = '0;
		inl_nx    = 1'b0;
		if (!ovf_q) begin
			if (tag_found_q) begin
				expect_nx = 1'b1;
				if (inline_ok && !inl_len[0]) begin
					// first pair of inline text is dropped
					expect_nx = 1'b0;
					emit_go   = inl_len >= LW'(4);
					first     = cp1 + LW'(2);
					inl_nx    = 1'b1;
				end
			end else if (expect_q && len_q != '0) begin
				expect_nx = 1'b0;
				emit_go   = !len_q[0];
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q         <= 1'b0;
			len_q        <= '0;
			colon_q      <= '0;
			colon_seen_q <= 1'b0;
			prog_q       <= '0;
			tag_found_q  <= 1'b0;
			expect_q     <= 1'b0;
			cr_q         <= 1'b0;
			ovf_q        <= 1'b0;
			ptr_q        <= '0;
			end_q        <= '0;
			inl_q        <= 1'b0;
			rd_last_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) en_q <= cfg_wdata;

			if (cmd.take_char) begin
				cr_q <= (rx_byte == ahpe_pkg::CHAR_CR);
				if (tag_hit) begin
					tag_found_q <= 1'b1;
					prog_q      <= '0;
				end else begin
					prog_q <= prog_inc;
				end
			end

			if (st_en) begin
				if (st_full) begin
					ovf_q <= 1'b1;
				end else begin
					if (st_char == ahpe_pkg::CHAR_COLON) begin
						colon_q      <= len_q[AW-1:0];
						colon_seen_q <= 1'b1;
					end
					len_q <= len_inc;
				end
			end

			if (cmd.end_line) begin
				expect_q     <= expect_nx;
				len_q        <= '0;
				colon_q      <= '0;
				colon_seen_q <= 1'b0;
				prog_q       <= '0;
				tag_found_q  <= 1'b0;
				cr_q         <= 1'b0;
				ovf_q        <= 1'b0;
				if (emit_go) begin
					ptr_q <= first;
					end_q <= len_q;
					inl_q <= inl_nx;
				end
			end

			if (cmd.rd_en) begin
				ptr_q     <= ptr_q + LW'(2);
				rd_last_q <= (ptr_q + LW'(2)) == end_q;
			end

			if (cmd.ld_out)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Character held while the pending CR is stored
	always_ff @(posedge clk) begin
		if (cmd.take_char) held_q <= rx_byte;
	end

	// Line store: one write port, two registered read ports
	logic [LW-1:0] ptr_p1;
	assign ptr_p1 = ptr_q + LW'(1);

	always_ff @(posedge clk) begin
		if (st_en && !st_full) nib_mem[len_q[AW-1:0]] <= ahpe_pkg::hex_value(st_char);
		if (cmd.rd_en) begin
			hi_q <= nib_mem[ptr_q[AW-1:0]];
			lo_q <= nib_mem[ptr_p1[AW-1:0]];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_byte_q <= {hi_q, lo_q};
			out_last_q <= rd_last_q;
			out_inl_q  <= inl_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = out_byte_q;
	assign last_in_frame = out_last_q;
	assign inline_format = out_inl_q;

	assign sts.enabled   = en_q;
	assign sts.is_nl     = rx_byte == ahpe_pkg::CHAR_NL;
	assign sts.need_held = cr_q && rx_byte != ahpe_pkg::CHAR_CR;
	assign sts.emit_go   = emit_go;
	assign sts.rd_last   = rd_last_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	`AHPE_ASSERT(a_len_bound, len_q <= LW'(LINE_MAX), "line length past store")
	`AHPE_ASSERT(a_colon_inside, colon_seen_q |-> (LW'(colon_q) < len_q), "colon past line end")
	`AHPE_ASSERT(a_rd_in_line, cmd.rd_en |-> ((ptr_q + LW'(1)) < end_q), "pair read past line end")

endmodule

/* src/at_event_hex_payload_extractor_core.sv */
// Channel   | Handshake               | Payload
// ----------+-------------------------+----------------------------------------------
// config    | cfg_we                  | cfg_wdata (receive_enable)
// input     | in_valid / in_ready     | rx_byte
// output    | out_valid / out_ready   | payload_byte, last_in_frame, inline_format
//
// An ordinary character is stored as it arrives; a character that follows a held CR
// needs a second store step, since the line store has a single write port.
// A newline ends the line; each emitted byte then takes a registered read of a
// nibble pair, then the output register; out_ready low stretches the load step.
// Reset clears all control state; the line store itself is not cleared.
// in_ready is high whenever the controller is idle, even while a result waits.
module at_event_hex_payload_extractor_core #(
	parameter int LINE_MAX = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       last_in_frame,
	output logic       inline_format
);

	ahpe_pkg::dp_cmd_t cmd;
	ahpe_pkg::dp_sts_t sts;

	ahpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ahpe_dp #(
		.LINE_MAX (LINE_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.rx_byte       (rx_byte),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.payload_byte  (payload_byte),
		.last_in_frame (last_in_frame),
		.inline_format (inline_format),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule
